// ----- src/lke_pkg.sv -----
// Shared types and constants for the lock-to-key encoder.
// No dependencies; used by lke_escape and lock_to_key_encoder.
package lke_pkg;

   localparam int LOCK_DEPTH = 256;
   localparam int ADDR_W     = $clog2(LOCK_DEPTH);
   localparam int CNT_W      = $clog2(LOCK_DEPTH + 1);

   // escape word count and index of its final word
   localparam int          ESC_LEN  = 10;
   localparam int          IDX_W    = $clog2(ESC_LEN);
   localparam logic [IDX_W-1:0] ESC_LAST = IDX_W'(ESC_LEN - 1);

   localparam logic [7:0] KEY_FIX = 8'd5;

   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_NOMORE   = 2'd1,
      ST_SHORT    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SEND,
      S_STAT
   } state_type;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_EMIT = 1'b1
   } req_type;

endpackage

// ----- src/lke_escape.sv -----
// Key byte formatter: picks the word at a given position of the output run.
// Escaped keys become /%DCNddd%/; depends on lke_pkg.
module lke_escape (
   input  logic [7:0]               key,
   input  logic [lke_pkg::IDX_W-1:0] idx,
   output logic                     escaped,
   output logic [7:0]               word
);
   import lke_pkg::*;

   logic [7:0] d2, d1, d0;

   // only six keys escape, so the decimal digits come from a small table
   always_comb begin
      escaped = 1'b1;
      d2 = 8'h30;
      d1 = 8'h30;
      d0 = 8'h30;
      case (key)
         8'd0: begin
         end
         8'd5: begin
            d0 = 8'h35;
         end
         8'd36: begin
            d1 = 8'h33;
            d0 = 8'h36;
         end
         8'd96: begin
            d1 = 8'h39;
            d0 = 8'h36;
         end
         8'd124: begin
            d2 = 8'h31;
            d1 = 8'h32;
            d0 = 8'h34;
         end
         8'd126: begin
            d2 = 8'h31;
            d1 = 8'h32;
            d0 = 8'h36;
         end
         default: begin
            escaped = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (!escaped) begin
         word = key;
      end else begin
         case (idx)
            IDX_W'(0): word = 8'h2F;   // '/'
            IDX_W'(1): word = 8'h25;   // '%'
            IDX_W'(2): word = 8'h44;   // 'D'
            IDX_W'(3): word = 8'h43;   // 'C'
            IDX_W'(4): word = 8'h4E;   // 'N'
            IDX_W'(5): word = d2;
            IDX_W'(6): word = d1;
            IDX_W'(7): word = d0;
            IDX_W'(8): word = 8'h25;   // '%'
            default:   word = 8'h2F;   // '/'
         endcase
      end
   end

endmodule

// ----- src/lock_to_key_encoder.sv -----
// Top level of the lock-to-key encoder: lock store, sequencer, output register.
// Depends on lke_pkg and lke_escape.
//
// Lock bytes stream in one word per load request and are kept in a
// single-port-write, single-port-read synchronous store of LOCK_DEPTH bytes;
// a load flagged first_of_lock restarts the lock. Bytes past the depth are
// dropped and set a sticky overflow mark. Each emit request returns the next
// key byte: byte 0 is lock[0]^lock[n-1]^lock[n-2]^5, byte i is
// lock[i]^lock[i-1], nibble-swapped; keys 0, 5, 36, 96, 124 and 126 go out as
// the ten-word escape /%DCNddd%/. An emit with overflow, fewer than two bytes
// loaded, or past the end returns one status word instead (out_byte 0).
// An emit is accepted, then makes 2 store reads (3 for key byte 0) through
// the one read port, then sends 1 or 10 output words at one per cycle while
// the output is not stalled. A status emit is accepted and then sends its
// single word. One request is in flight at a time. The store has no reset;
// only entries written in the current lock are ever read.
module lock_to_key_encoder (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] lock_byte
   input  logic [1:0] req_tuser,   // [0] req_type, [1] first_of_lock
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // seq_last
   output logic [2:0] rsp_tuser    // [0] key_end, [2:1] status
);
   import lke_pkg::*;

   // lock store
   logic [7:0] lock_store [LOCK_DEPTH];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lock_store[wr_addr] <= req_tdata;
      end
      rd_data_ff <= lock_store[rd_addr];
   end

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              ovf_ff, ovf_in;

   // per-request working registers
   logic              zero_ff, zero_in;       // emitting key byte 0
   logic              end_ff, end_in;         // this request ends the key
   logic [ADDR_W-1:0] idx_ff, idx_in;         // key byte index
   logic [1:0]        step_ff, step_in;       // read whose data is arriving
   logic [7:0]        acc_ff, acc_in;
   logic [7:0]        key_ff, key_in;
   logic [IDX_W-1:0]  send_ff, send_in;
   status_type        stat_ff, stat_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_end_ff, rsp_end_in;
   status_type        rsp_stat_ff, rsp_stat_in;

   logic              esc;
   logic [7:0]        esc_word;

   lke_escape u_escape (
      .key     (key_ff),
      .idx     (send_ff),
      .escaped (esc),
      .word    (esc_word)
   );

   logic             accept;
   logic             is_emit;
   logic             first;
   logic             out_free;
   logic [CNT_W-1:0] base;
   logic [CNT_W-1:0] pos_next;
   logic [CNT_W-1:0] cnt_less1;
   logic [CNT_W-1:0] cnt_less2;
   logic [7:0]       raw;
   logic             last_step;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_emit    = (req_tuser[0] == REQ_EMIT);
   assign first      = req_tuser[1];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign base       = first ? '0 : cnt_ff;
   assign pos_next   = pos_ff + CNT_W'(1);
   assign cnt_less1  = cnt_ff - CNT_W'(1);
   assign cnt_less2  = cnt_ff - CNT_W'(2);
   assign last_step  = (step_ff == (zero_ff ? 2'd2 : 2'd1));
   assign raw        = acc_ff ^ rd_data_ff ^ (zero_ff ? KEY_FIX : 8'd0);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      zero_in      = zero_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      key_in       = key_ff;
      send_in      = send_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_stat_in  = rsp_stat_ff;
      wr_en        = 1'b0;
      wr_addr      = base[ADDR_W-1:0];
      rd_addr      = pos_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept && !is_emit) begin
               if (first) begin
                  pos_in = '0;
                  ovf_in = 1'b0;
               end
               if (base < CNT_W'(LOCK_DEPTH)) begin
                  wr_en  = 1'b1;
                  cnt_in = base + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (accept) begin
               if (ovf_ff) begin
                  stat_in  = ST_OVERFLOW;
                  state_in = S_STAT;
               end else if (cnt_ff < CNT_W'(2)) begin
                  stat_in  = ST_SHORT;
                  state_in = S_STAT;
               end else if (pos_ff >= cnt_ff) begin
                  stat_in  = ST_NOMORE;
                  state_in = S_STAT;
               end else begin
                  // first read (lock[i], or lock[0] for byte 0) goes out now
                  zero_in  = (pos_ff == '0);
                  idx_in   = pos_ff[ADDR_W-1:0];
                  end_in   = (pos_next == cnt_ff);
                  pos_in   = pos_next;
                  step_in  = 2'd0;
                  state_in = S_READ;
               end
            end
         end

         S_READ: begin
            // address for the read after the one now returning
            if (zero_ff) begin
               rd_addr = (step_ff == 2'd0) ? cnt_less1[ADDR_W-1:0]
                                             : cnt_less2[ADDR_W-1:0];
            end else begin
               rd_addr = idx_ff - ADDR_W'(1);
            end
            if (step_ff == 2'd0) begin
               acc_in = rd_data_ff;
            end else begin
               acc_in = acc_ff ^ rd_data_ff;
            end
            step_in = step_ff + 2'd1;
            if (last_step) begin
               key_in   = {raw[3:0], raw[7:4]};
               send_in  = '0;
               state_in = S_SEND;
            end
         end

         S_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = esc_word;
               rsp_last_in  = !esc || (send_ff == ESC_LAST);
               rsp_end_in   = end_ff;
               rsp_stat_in  = ST_DATA;
               send_in      = send_ff + IDX_W'(1);
               if (!esc || (send_ff == ESC_LAST)) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_STAT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'd0;
               rsp_last_in  = 1'b1;
               rsp_end_in   = 1'b0;
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff     <= zero_in;
      end_ff      <= end_in;
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      key_ff      <= key_in;
      send_ff     <= send_in;
      stat_ff     <= stat_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_stat_ff, rsp_end_ff};

endmodule

// ----- dv/lock_to_key_encoder_tb.sv -----
// Self-checking bench for lock_to_key_encoder: random lock sessions, escapes and status replies.
// Depends on lke_pkg and the RTL under src/; words are predicted in-bench and compared in order.
`timescale 1ns / 100ps

module lock_to_key_encoder_tb;
   import lke_pkg::*;

   // one request word as the bench sees it
   typedef struct packed {
      req_type    kind;
      logic [7:0] lock_byte;
      logic       first;
   } lock_req_type;

   // one response word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       seq_last;
      logic       key_end;
      status_type status;
   } key_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] lock_byte
   logic [1:0] req_tuser = 2'b00;   // [0] req_type, [1] first_of_lock
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // seq_last
   logic [2:0] rsp_tuser;           // [0] key_end, [2:1] status

   lock_to_key_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // pending requests, and the key words they are expected to produce
   lock_req_type req_q[$];
   key_word_type key_words[$];
   lock_req_type cur_req;

   // bench copy of the encoder state
   logic [7:0] lock_mem [0:LOCK_DEPTH-1];
   int         lock_len = 0;
   int         key_pos = 0;
   logic       lock_overflow = 1'b0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int n_loads = 0;
   int n_emits = 0;
   int n_escaped = 0;
   int n_status = 0;
   int n_checked = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // generous bound; a correct run needs well under a tenth of this
   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [7:0] nib_swap(input logic [7:0] b);
      return {b[3:0], b[7:4]};
   endfunction

   function automatic logic is_escaped(input logic [7:0] k);
      return k == 8'd0 || k == 8'd5 || k == 8'd36 || k == 8'd96 || k == 8'd124 || k == 8'd126;
   endfunction

   // the six key values that go out as an escape, by index
   function automatic logic [7:0] escape_key(input int idx);
      case (idx)
         0: return 8'd0;
         1: return 8'd5;
         2: return 8'd36;
         3: return 8'd96;
         4: return 8'd124;
         default: return 8'd126;
      endcase
   endfunction

   function automatic void push_word(input logic [7:0] b, input logic seq_last,
                                     input logic key_end, input status_type st);
      key_word_type w;
      w.out_byte = b;
      w.seq_last = seq_last;
      w.key_end  = key_end;
      w.status   = st;
      key_words.insert(key_words.size(), w);
   endfunction

   // advance the bench state by one accepted request, queue its key words
   function automatic void encode_request(input lock_req_type r);
      logic [7:0] k;
      logic       at_end;
      logic [7:0] esc [0:9];
      if (r.kind == REQ_LOAD) begin
         n_loads++;
         if (r.first) begin
            lock_len = 0;
            key_pos = 0;
            lock_overflow = 1'b0;
         end
         if (lock_len < LOCK_DEPTH) begin
            lock_mem[lock_len] = r.lock_byte;
            lock_len++;
         end else begin
            lock_overflow = 1'b1;   // byte dropped, mark sticks until next first
         end
         return;
      end
      n_emits++;
      // overflow wins over short, short wins over past-the-end
      if (lock_overflow) begin
         n_status++;
         push_word(8'h00, 1'b1, 1'b0, ST_OVERFLOW);
      end else if (lock_len < 2) begin
         n_status++;
         push_word(8'h00, 1'b1, 1'b0, ST_SHORT);
      end else if (key_pos >= lock_len) begin
         n_status++;
         push_word(8'h00, 1'b1, 1'b0, ST_NOMORE);
      end else begin
         if (key_pos == 0)
            k = lock_mem[0] ^ lock_mem[lock_len-1] ^ lock_mem[lock_len-2] ^ KEY_FIX;
         else
            k = lock_mem[key_pos] ^ lock_mem[key_pos-1];
         k = nib_swap(k);
         key_pos++;
         at_end = (key_pos == lock_len);
         if (!is_escaped(k)) begin
            push_word(k, 1'b1, at_end, ST_DATA);
         end else begin
            n_escaped++;
            esc[0] = "/";
            esc[1] = "%";
            esc[2] = "D";
            esc[3] = "C";
            esc[4] = "N";
            esc[5] = 8'("0" + k / 100);
            esc[6] = 8'("0" + (k / 10) % 10);
            esc[7] = 8'("0" + k % 10);
            esc[8] = "%";
            esc[9] = "/";
            for (int j = 0; j < 10; j++)
               push_word(esc[j], j == 9, at_end, ST_DATA);
         end
      end
   endfunction

   function automatic void queue_req(input req_type kind, input logic [7:0] b, input logic first);
      lock_req_type r;
      r.kind = kind;
      r.lock_byte = b;
      r.first = first;
      req_q.insert(req_q.size(), r);
   endfunction

   function automatic void queue_emit();
      queue_req(REQ_EMIT, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endfunction

   // short hand-picked run: empty and one-byte locks, every escape value,
   // escape on key byte 0, byte extremes, past-the-end emit
   function automatic void queue_directed();
      logic [7:0] a [0:7];
      queue_req(REQ_EMIT, 8'hFF, 1'b1);       // nothing loaded yet
      queue_req(REQ_LOAD, 8'h00, 1'b1);
      queue_req(REQ_EMIT, 8'h00, 1'b0);       // one byte only
      a[0] = 8'hFF;
      for (int i = 1; i <= 6; i++)
         a[i] = a[i-1] ^ nib_swap(escape_key(i - 1));
      a[7] = a[0] ^ a[6] ^ KEY_FIX ^ nib_swap(escape_key(0));
      for (int i = 0; i < 8; i++)
         queue_req(REQ_LOAD, a[i], i == 0);
      for (int i = 0; i < 9; i++)
         queue_req(REQ_EMIT, 8'h00, 1'b0);    // last one runs past the end
   endfunction

   // mostly well-formed lock sessions with random content, some noise
   function automatic int queue_session();
      logic [7:0] a [0:15];
      int         len;
      int         r;
      int         n;
      n = 0;
      r = $urandom_range(99);
      if (r < 8) begin
         queue_emit();              // stray emit in whatever state we are in
         return 1;
      end
      if (r < 15) begin
         // broken session: a single byte, then an emit or two
         queue_req(REQ_LOAD, 8'($urandom_range(255)), 1'b1);
         queue_emit();
         if ($urandom_range(1)) begin
            queue_emit();
            return 3;
         end
         return 2;
      end
      len = $urandom_range(2, 12);
      a[0] = 8'($urandom_range(255));
      for (int i = 1; i < len; i++) begin
         if ($urandom_range(99) < 35)
            a[i] = a[i-1] ^ nib_swap(escape_key($urandom_range(5)));
         else
            a[i] = 8'($urandom_range(255));
      end
      if ($urandom_range(99) < 20)     // make key byte 0 an escape
         a[len-1] = a[0] ^ a[len-2] ^ KEY_FIX ^ nib_swap(escape_key($urandom_range(5)));
      for (int i = 0; i < len; i++)
         queue_req(REQ_LOAD, a[i], i == 0);
      n = len;
      for (int i = 0; i < len + $urandom_range(2); i++) begin
         if ($urandom_range(99) < 12) begin
            // append to the running lock; first clear so the session goes on
            queue_req(REQ_LOAD, 8'($urandom_range(255)), 1'b0);
            n++;
         end
         queue_emit();
         n++;
      end
      return n;
   endfunction

   function automatic void queue_random(input int n_items);
      int n;
      n = 0;
      while (n < n_items)
         n += queue_session();
   endfunction

   // fill the store to the brim, emit around key byte 0, then overflow it
   function automatic void queue_full_lock();
      for (int i = 0; i < LOCK_DEPTH; i++)
         queue_req(REQ_LOAD, 8'($urandom_range(255)), i == 0);
      for (int i = 0; i < 3; i++)
         queue_emit();
      queue_req(REQ_LOAD, 8'($urandom_range(255)), 1'b0);
      queue_emit();
      queue_req(REQ_LOAD, 8'($urandom_range(255)), 1'b0);
      queue_emit();
      queue_emit();
   endfunction

   // request driver: presents words from req_q, holds until accepted
   always @(posedge clock) begin : drive_req
      lock_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            encode_request(cur_req);
         if (!req_tvalid || req_tready) begin
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = req_q.pop_front();
               cur_req    <= nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.lock_byte;
               req_tuser  <= {nxt.first, nxt.kind};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor: random backpressure, in-order compare
   always @(posedge clock) begin : watch_rsp
      key_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (key_words.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected word: byte %h last %b end %b status %0d", $time,
                     rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[2:1]);
         end else begin
            e = key_words.pop_front();
            n_checked++;
            if (rsp_tdata !== e.out_byte || rsp_tlast !== e.seq_last ||
                rsp_tuser[0] !== e.key_end || rsp_tuser[2:1] !== e.status) begin
               fail_count++;
               $display({"%0t: mismatch: expected byte %h last %b end %b status %0d,",
                         " got byte %h last %b end %b status %0d"},
                        $time, e.out_byte, e.seq_last, e.key_end, e.status,
                        rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[2:1]);
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // phase sequencing; each phase drains its requests before the next
   initial begin : run_phases
      int idle_tab [0:3];
      int stall_tab [0:3];
      idle_tab  = '{0, 83, 0, 18};
      stall_tab = '{0, 0, 83, 18};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_tab[p];
         recv_stall_pct = stall_tab[p];
         if (p == 0)
            queue_directed();
         if (p == 3)
            queue_full_lock();
         queue_random(43);
         @(posedge clock);
         while (req_q.size() != 0 || req_tvalid)
            @(posedge clock);
      end
      while (key_words.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);   // room for a stray late word
      $display("Run covered %0d loads and %0d emits: %0d escaped keys, %0d status replies.",
               n_loads, n_emits, n_escaped, n_status);
      $display("%0d response words checked over four idle/stall phases.", n_checked);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
